### rtl/bls_pkg.sv
// Shared types and codes for the line stepper.
// Used by every module of the block; depends on nothing.
package bls_pkg;

	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	// Step direction of one axis, as a two-bit signed value.
	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	localparam int QDEPTH = 2;

	localparam logic [0:0] REG_OMIT_END = 1'b0;

	typedef struct packed {
		logic       func;
		logic [1:0] dir_x;
		logic [1:0] dir_y;
	} bls_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} bls_qstat_t;

endpackage

### rtl/bls_front.sv
// Command intake: registers a word, then works out spans, directions and the
// initial error term before the word enters the queue. Depends on bls_pkg.
module bls_front import bls_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int ENTRY_W    = $bits(bls_ctrl_t) + 7 * COORD_BITS + 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic                         func,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  bls_qstat_t                   q_stat,
	output logic                         q_push,
	output logic [ENTRY_W-1:0]           q_data
);

	localparam int W = COORD_BITS;

	logic           valid_s1;
	logic           func_s1;
	logic [W-1:0]   x0_s1, y0_s1, x1_s1, y1_s1;
	logic [W:0]     ddx_s1, ddy_s1;
	logic           load_s1;
	logic [W:0]     span_x, span_y;
	logic [W+1:0]   err0;
	bls_ctrl_t      ctrl;

	assign q_push    = valid_s1 && !q_stat.full;
	assign load_s1   = !valid_s1 || q_push;
	assign cmd_stall = valid_s1 && q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && cmd_valid) begin
			func_s1 <= func;
			x0_s1   <= start_x;
			y0_s1   <= start_y;
			x1_s1   <= end_x;
			y1_s1   <= end_y;
			ddx_s1  <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
			ddy_s1  <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
		end
	end

	always_comb begin
		span_x = ddx_s1[W] ? (~ddx_s1 + 1'b1) : ddx_s1;
		span_y = ddy_s1[W] ? (~ddy_s1 + 1'b1) : ddy_s1;
		err0   = {1'b0, span_x} - {1'b0, span_y};
		ctrl.func  = func_s1;
		ctrl.dir_x = (ddx_s1 == '0) ? DIR_ZERO : (ddx_s1[W] ? DIR_NEG : DIR_POS);
		ctrl.dir_y = (ddy_s1 == '0) ? DIR_ZERO : (ddy_s1[W] ? DIR_NEG : DIR_POS);
	end

	assign q_data = {ctrl, x0_s1, y0_s1, x1_s1, y1_s1, span_x, span_y, err0};

endmodule

### rtl/bls_queue.sv
// Short queue between the intake and the stepper so each side stalls alone.
// Depends on bls_pkg for its depth and status type.
module bls_queue import bls_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output bls_qstat_t        stat
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [DATA_W-1:0] slot_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign stat.full  = (count_q == CNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty)) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

### rtl/bls_back.sv
// Stepper: holds the line state, makes one error-term step per start word or per
// advance of a running line, and registers the pixel result. Depends on bls_pkg.
module bls_back import bls_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int ENTRY_W    = $bits(bls_ctrl_t) + 7 * COORD_BITS + 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ENTRY_W-1:0]           q_data,
	input  bls_qstat_t                   q_stat,
	output logic                         q_pop,
	input  logic                         omit_end,
	output logic                         pix_valid,
	input  logic                         pix_stall,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         plot,
	output logic                         last,
	output logic                         valid_res
);

	localparam int W  = COORD_BITS;
	localparam int EW = COORD_BITS + 2;
	localparam int TW = COORD_BITS + 4;

	bls_ctrl_t    e_ctrl;
	logic [W-1:0] e_x0, e_y0, e_x1, e_y1;
	logic [W:0]   e_sx, e_sy;
	logic [EW-1:0] e_err;

	// The position and error held here are those after the look-ahead step,
	// i.e. the pixel the next advance will report.
	logic [W-1:0]  pos_x_q, pos_y_q, goal_x_q, goal_y_q;
	logic [W:0]    span_x_q, span_y_q;
	logic [EW-1:0] err_q;
	logic [1:0]    dir_x_q, dir_y_q;
	logic          active_q;

	logic          pix_valid_q;
	logic [W-1:0]  pixel_x_q, pixel_y_q;
	logic          plot_q, last_q, valid_res_q;

	logic          fire, is_start, live;
	logic [W-1:0]  bx, by, gx, gy, nx, ny;
	logic [W:0]    sx, sy;
	logic [EW-1:0] be, ne;
	logic [1:0]    dx, dy;
	logic [TW-1:0] e2, lhs_x, lhs_y, thr;
	logic          cond_x, cond_y, fin;

	assign {e_ctrl, e_x0, e_y0, e_x1, e_y1, e_sx, e_sy, e_err} = q_data;

	assign fire     = !q_stat.empty && (!pix_valid_q || !pix_stall);
	assign q_pop    = fire;
	assign is_start = (e_ctrl.func == FUNC_START);
	assign live     = is_start || active_q;

	always_comb begin
		bx = is_start ? e_x0 : pos_x_q;
		by = is_start ? e_y0 : pos_y_q;
		gx = is_start ? e_x1 : goal_x_q;
		gy = is_start ? e_y1 : goal_y_q;
		sx = is_start ? e_sx : span_x_q;
		sy = is_start ? e_sy : span_y_q;
		be = is_start ? e_err : err_q;
		dx = is_start ? e_ctrl.dir_x : dir_x_q;
		dy = is_start ? e_ctrl.dir_y : dir_y_q;

		// Ties go the other way when x runs backward.
		thr   = {{(TW-1){1'b0}}, (dx == DIR_NEG)};
		e2    = {be[EW-1], be, 1'b0};
		lhs_x = e2 + {3'b000, sy};
		lhs_y = e2 - {3'b000, sx} + thr;
		cond_x = ($signed(lhs_x) >= $signed(thr));
		cond_y = lhs_y[TW-1] || (lhs_y == '0);

		fin = (cond_x && (bx == gx)) || (cond_y && (by == gy));
		nx  = cond_x ? bx + {{(W-2){dx[1]}}, dx} : bx;
		ny  = cond_y ? by + {{(W-2){dy[1]}}, dy} : by;
		ne  = be - (cond_x ? {1'b0, sy} : '0) + (cond_y ? {1'b0, sx} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pix_valid_q <= 1'b1;
				if (live) begin
					active_q <= !fin;
				end
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (live) begin
				pos_x_q <= nx;
				pos_y_q <= ny;
				err_q   <= ne;
			end
			if (is_start) begin
				goal_x_q <= e_x1;
				goal_y_q <= e_y1;
				span_x_q <= e_sx;
				span_y_q <= e_sy;
				dir_x_q  <= e_ctrl.dir_x;
				dir_y_q  <= e_ctrl.dir_y;
			end
			if (live) begin
				pixel_x_q   <= bx;
				pixel_y_q   <= by;
				plot_q      <= !(fin && omit_end);
				last_q      <= fin;
				valid_res_q <= 1'b1;
			end else begin
				pixel_x_q   <= '0;
				pixel_y_q   <= '0;
				plot_q      <= 1'b0;
				last_q      <= 1'b0;
				valid_res_q <= 1'b0;
			end
		end
	end

	assign pix_valid = pix_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign plot      = plot_q;
	assign last      = last_q;
	assign valid_res = valid_res_q;

`ifndef SYNTHESIS
	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_q && !valid_res_q |-> (pixel_x_q == '0) && (pixel_y_q == '0)
			&& !plot_q && !last_q) else $error("idle result carries pixel data");
	a_end_clears_line: assert property (@(posedge clk) disable iff (!arst_n)
		fire && live && fin |=> !active_q) else $error("line still active after end");
	a_hidden_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_q && valid_res_q && !plot_q |-> last_q)
		else $error("unplotted pixel that is not the last");
`endif

endmodule

### rtl/bresenham_line_stepper.sv
// Top level of the all-octant line stepper: register port, intake, queue and
// stepper. Depends on bls_pkg, bls_front, bls_queue and bls_back.
//
// Usage: a command word (func = start with both endpoints, or advance) goes in
// on cmd_valid/cmd_stall; every command word gives exactly one result word
// on pix_valid/pix_stall carrying pixel_x, pixel_y, plot, last and valid_res.
// A start reports the first pixel; each advance reports the next one, and
// last marks the end pixel. An advance with no line running gives a word
// with valid_res low and all other fields zero.
// The command word passes through the intake register and a queue slot, and the
// result word is registered. One word per cycle is sustained while pix_stall is
// low: the stepper makes one add-and-compare error step per cycle.
// Register omit_end (byte address 0) selects segment mode, where the end
// pixel is reported with plot low; write it only while the block is idle.
// Reset clears the line state, omit_end and all handshakes. When the
// receiver stalls, the result word holds; the two-entry queue plus the
// intake register keep taking commands until they fill, then cmd_stall rises.
module bresenham_line_stepper import bls_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic                         func,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         pix_valid,
	input  logic                         pix_stall,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         plot,
	output logic                         last,
	output logic                         valid_res
);

	localparam int ENTRY_W = $bits(bls_ctrl_t) + 7 * COORD_BITS + 4;

	logic               omit_end_q;
	logic               reg_hit;
	logic               q_push, q_pop;
	logic [ENTRY_W-1:0] q_wdata, q_rdata;
	bls_qstat_t         q_stat;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_OMIT_END) && (paddr[1:0] == 2'b00);
	assign prdata  = reg_hit ? {31'd0, omit_end_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omit_end_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			omit_end_q <= pwdata[0];
		end
	end

	bls_front #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.func      (func),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	bls_queue #(
		.DATA_W (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	bls_back #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rdata),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.omit_end  (omit_end_q),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.plot      (plot),
		.last      (last),
		.valid_res (valid_res)
	);

endmodule
